[hdl/npe_pkg.sv]
// ----------------------------------------------------------------------------
// npe_pkg: shared constants and types of the next permutation engine
// Capacity, index widths, element type and the memory request bundle.
// ----------------------------------------------------------------------------
package npe_pkg;

	localparam int MAX_LEN = 16;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ELEM_W  = 16;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		elem_t wdata;
		idx_t  raddr;
	} mem_req_t;

	typedef struct packed {
		elem_t element;
		logic  fin;
		logic  wrapped;
		logic  overflowed;
	} emit_t;

endpackage

[hdl/npe_if.sv]
// ----------------------------------------------------------------------------
// npe_if: channel interfaces of the next permutation engine
// Input element channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface npe_feed_if
	import npe_pkg::*;
();
	logic  valid;
	logic  ready;
	elem_t element;
	logic  is_final;

	modport source (output valid, output element, output is_final, input ready);
	modport sink   (input valid, input element, input is_final, output ready);
endinterface

interface npe_result_if
	import npe_pkg::*;
();
	logic  valid;
	logic  ready;
	elem_t out_element;
	logic  out_final;
	logic  wrapped;
	logic  overflowed;

	modport source (output valid, output out_element, output out_final,
		output wrapped, output overflowed, input ready);
	modport sink   (input valid, input out_element, input out_final,
		input wrapped, input overflowed, output ready);
endinterface

[hdl/npe_ram.sv]
// ----------------------------------------------------------------------------
// npe_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/npe_seq.sv]
// ----------------------------------------------------------------------------
// npe_seq: load and permutation sequencer
// Loads the sequence into the store, finds the pivot, swaps, reverses the
// suffix and streams the result, one memory access per state.
// ----------------------------------------------------------------------------
module npe_seq
	import npe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	npe_feed_if.sink         feed,
	output mem_req_t         mem_req,
	input  elem_t            mem_rdata,
	output logic             emit_valid,
	input  logic             emit_ready,
	output emit_t            emit
);
	typedef enum logic [3:0] {
		S_LOAD,
		S_SC_RD,
		S_SC_CMP,
		S_FN_RD,
		S_FN_CMP,
		S_SW_WA,
		S_SW_WB,
		S_RV_RDA,
		S_RV_RDB,
		S_RV_WA,
		S_RV_WB,
		S_EM_RD,
		S_EM_OUT
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;
	logic   ovf_q;
	logic   wrap_q;
	idx_t   last_q;
	idx_t   ptr_q;
	idx_t   piv_q;
	idx_t   lo_q;
	idx_t   hi_q;
	elem_t  right_q;
	elem_t  pv_q;
	elem_t  kval_q;
	elem_t  a_q;
	logic   room;
	cnt_t   n_next;

	assign room   = (cnt_q < CNT_W'(MAX_LEN));
	assign n_next = room ? cnt_q + CNT_W'(1) : cnt_q;

	assign feed.ready = (state_q == S_LOAD);

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = ptr_q;
		mem_req.wdata = feed.element;
		mem_req.raddr = ptr_q;
		unique case (state_q)
			S_LOAD: begin
				mem_req.we    = feed.valid && room;
				mem_req.waddr = cnt_q[IDX_W-1:0];
			end
			S_SW_WA: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q;
				mem_req.wdata = pv_q;
			end
			S_SW_WB: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = piv_q;
				mem_req.wdata = kval_q;
			end
			S_RV_RDA: begin
				mem_req.raddr = lo_q;
			end
			S_RV_RDB: begin
				mem_req.raddr = hi_q;
			end
			S_RV_WA: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = lo_q;
				mem_req.wdata = mem_rdata;
			end
			S_RV_WB: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = hi_q;
				mem_req.wdata = a_q;
			end
			default: begin
			end
		endcase
	end

	assign emit_valid      = (state_q == S_EM_OUT);
	assign emit.element    = mem_rdata;
	assign emit.fin        = (ptr_q == last_q);
	assign emit.wrapped    = wrap_q;
	assign emit.overflowed = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			wrap_q  <= 1'b0;
			last_q  <= '0;
			ptr_q   <= '0;
			piv_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			right_q <= '0;
			pv_q    <= '0;
			kval_q  <= '0;
			a_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (feed.valid) begin
						cnt_q <= n_next;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (feed.is_final) begin
							wrap_q <= 1'b0;
							last_q <= IDX_W'(n_next - CNT_W'(1));
							if (n_next == CNT_W'(1)) begin
								ptr_q   <= '0;
								state_q <= S_EM_RD;
							end else begin
								ptr_q   <= IDX_W'(n_next - CNT_W'(1));
								state_q <= S_SC_RD;
							end
						end
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					if (ptr_q != last_q && mem_rdata < right_q) begin
						pv_q    <= mem_rdata;
						piv_q   <= ptr_q;
						ptr_q   <= last_q;
						state_q <= S_FN_RD;
					end else if (ptr_q == '0) begin
						wrap_q  <= 1'b1;
						lo_q    <= '0;
						hi_q    <= last_q;
						state_q <= S_RV_RDA;
					end else begin
						right_q <= mem_rdata;
						ptr_q   <= ptr_q - IDX_W'(1);
						state_q <= S_SC_RD;
					end
				end
				S_FN_RD: begin
					state_q <= S_FN_CMP;
				end
				S_FN_CMP: begin
					if (mem_rdata > pv_q) begin
						kval_q  <= mem_rdata;
						state_q <= S_SW_WA;
					end else begin
						ptr_q   <= ptr_q - IDX_W'(1);
						state_q <= S_FN_RD;
					end
				end
				S_SW_WA: begin
					state_q <= S_SW_WB;
				end
				S_SW_WB: begin
					lo_q    <= piv_q + IDX_W'(1);
					hi_q    <= last_q;
					state_q <= S_RV_RDA;
				end
				S_RV_RDA: begin
					if (lo_q < hi_q) begin
						state_q <= S_RV_RDB;
					end else begin
						ptr_q   <= '0;
						state_q <= S_EM_RD;
					end
				end
				S_RV_RDB: begin
					a_q     <= mem_rdata;
					state_q <= S_RV_WA;
				end
				S_RV_WA: begin
					state_q <= S_RV_WB;
				end
				S_RV_WB: begin
					lo_q    <= lo_q + IDX_W'(1);
					hi_q    <= hi_q - IDX_W'(1);
					state_q <= S_RV_RDA;
				end
				S_EM_RD: begin
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (emit_ready) begin
						if (ptr_q == last_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							ptr_q   <= ptr_q + IDX_W'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && mem_req.we) |-> cnt_q < CNT_W'(MAX_LEN))
		else $error("store written beyond capacity");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_CMP || state_q == S_FN_CMP) |-> ptr_q <= last_q)
		else $error("scan index beyond sequence end");

	a_flip_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RV_WA || state_q == S_RV_WB) |-> lo_q < hi_q)
		else $error("reversal pointers crossed");

	a_partner_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FN_CMP) |-> ptr_q > piv_q)
		else $error("swap partner search passed the pivot");

	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && emit_ready && emit.fin) |=> (state_q == S_LOAD && cnt_q == '0))
		else $error("count not cleared after last result");
endmodule

[hdl/next_permutation_engine.sv]
// ----------------------------------------------------------------------------
// next_permutation_engine: next lexicographic permutation of a sequence
// Usage:
//   feed   : one signed 16-bit element per transaction, is_final on the last.
//            Up to MAX_LEN elements are kept; further ones are dropped and
//            overflowed is set on every result of that sequence.
//   result : the next permutation, one element per transaction, first
//            position first, out_final on the last. wrapped is set when the
//            input was the greatest permutation and came back ascending.
// Throughput: loading accepts one element per cycle. After the final element
//   the sequence is permuted in place in a store with one read port and
//   registered read data: the pivot is searched from the end, then its swap
//   partner from the end and the two swapped; the suffix after the pivot (all
//   of it when there is none) is reversed pair by pair, and the elements are
//   read out in order. feed is not ready until the last result has been
//   taken by the output register.
// Reset clears the sequencer and the output valid flag; the store and the
//   output data need no clearing. When result.ready is low and the output
//   register holds a transaction, it keeps it and the sequencer waits.
// ----------------------------------------------------------------------------
module next_permutation_engine
	import npe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	npe_feed_if.sink   feed,
	npe_result_if.source result
);
	mem_req_t mem_req;
	elem_t    mem_rdata;
	logic     emit_valid;
	logic     emit_ready;
	emit_t    emit;
	logic     out_v_q;
	emit_t    out_q;

	npe_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_LEN)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	npe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit       (emit)
	);

	assign emit_ready = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_ready) begin
			out_v_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) begin
			out_q <= emit;
		end
	end

	assign result.valid       = out_v_q;
	assign result.out_element = out_q.element;
	assign result.out_final   = out_q.fin;
	assign result.wrapped     = out_q.wrapped;
	assign result.overflowed  = out_q.overflowed;
endmodule
